>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, quiet in reset.
`define KFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kfi: same-cycle check failed");

// Next-cycle implication, checked on the rising edge, quiet in reset.
`define KFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kfi: next-cycle check failed");

`endif

>>> rtl/kfi_pkg.sv
// Shared types, constants and helpers of the keyframe servo interpolator.
package kfi_pkg;

	localparam int ACTUATORS_DEF = 8;
	localparam int STEPS_DEF     = 16;
	localparam int MAX_OUT       = 8;

	localparam int PULSE_W = 10;
	localparam int TICK_W  = 16;
	localparam int PROD_W  = PULSE_W + TICK_W;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int USER_W     = 2;

	localparam logic [PULSE_W-1:0] PULSE_MIN = 10'd120;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 10'd800;
	localparam logic [7:0]         ANGLE_MAX = 8'd180;
	// ceil(65536 * 680 / 180): exact after >> 16 for angles up to 180
	localparam logic [17:0]        ANGLE_SCALE = 18'd247581;

	// register indexes on the configuration port
	localparam logic [1:0] REG_STEP_COUNT     = 2'd0;
	localparam logic [1:0] REG_ACTUATOR_COUNT = 2'd1;
	localparam logic [1:0] REG_STEP_TICKS     = 2'd2;
	localparam logic [1:0] REG_RUN            = 2'd3;

	localparam logic [4:0]        STEP_COUNT_RST = 5'd4;
	localparam logic [TICK_W-1:0] STEP_TICKS_RST = 16'd250;

	typedef enum logic [USER_W-1:0] {
		OP_KEYFRAME = 2'd0,
		OP_CHANNEL  = 2'd1,
		OP_TICK     = 2'd2
	} op_t;

	typedef struct packed {
		logic               start;
		logic [PULSE_W-1:0] cur;
		logic [PULSE_W-1:0] nxt;
		logic [TICK_W-1:0]  ph;
		logic [TICK_W-1:0]  ticks;
	} interp_req_t;

	typedef struct packed {
		logic               done;
		logic [PULSE_W-1:0] pulse;
	} interp_rsp_t;

	// 120 + angle*680/180, truncated, angle saturated at 180
	function automatic logic [PULSE_W-1:0] angle_to_pulse(input logic [7:0] angle);
		logic [7:0]  a;
		logic [25:0] p;
		a = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
		p = 26'(a) * 26'(ANGLE_SCALE);
		return PULSE_MIN + p[25:16];
	endfunction

endpackage

>>> rtl/kfi_kf_mem.sv
// Keyframe store: one write and one registered read port, cleared after reset.
module kfi_kf_mem import kfi_pkg::*; #(
	parameter int ACTUATORS = ACTUATORS_DEF,
	parameter int STEPS     = STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [((ACTUATORS > 1) ? $clog2(ACTUATORS) : 1) + $clog2(STEPS)-1:0] wr_addr,
	input  logic [PULSE_W-1:0] wr_data,
	input  logic [((ACTUATORS > 1) ? $clog2(ACTUATORS) : 1) + $clog2(STEPS)-1:0] rd_addr,
	output logic [PULSE_W-1:0] rd_data,
	output logic clearing
);

	localparam int AW     = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
	localparam int SW     = $clog2(STEPS);
	localparam int ADDR_W = AW + SW;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [PULSE_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0]  clr_q;
	logic               clearing_q;
	logic [PULSE_W-1:0] rd_data_q;

	// sweep every entry to the rest pulse once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= PULSE_MIN;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

>>> rtl/kfi_interp.sv
// Bit-serial interpolation unit: shift-add multiply then restoring divide.
module kfi_interp import kfi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  interp_req_t req,
	output interp_rsp_t rsp
);

	localparam int CNT_W = $clog2(PULSE_W);

	typedef enum logic [1:0] {
		I_IDLE,
		I_MUL,
		I_DIV,
		I_FIN
	} istate_t;

	istate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  acc_q;
	logic [PULSE_W-1:0] mq_q;
	logic [PULSE_W-1:0] cur_q;
	logic               neg_q;
	logic               done_q;
	logic [PULSE_W-1:0] pulse_q;

	logic [TICK_W:0]    trial;
	logic [TICK_W:0]    diff;
	logic               ge;
	logic [TICK_W-1:0]  new_rem;
	logic [PULSE_W-1:0] quo;
	logic               rem_nz;

	// one quotient bit per cycle: the remainder sits above the dividend bits
	assign trial   = {acc_q[PROD_W-1:PULSE_W], acc_q[PULSE_W-1]};
	assign diff    = trial - {1'b0, req.ticks};
	assign ge      = (trial >= {1'b0, req.ticks});
	assign new_rem = ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
	assign quo     = acc_q[PULSE_W-1:0];
	assign rem_nz  = (acc_q[PROD_W-1:PULSE_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
			mq_q    <= '0;
			cur_q   <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			pulse_q <= '0;
		end else begin
			done_q <= (state_q == I_FIN);
			unique case (state_q)
				I_IDLE: begin
					if (req.start) begin
						cur_q   <= req.cur;
						neg_q   <= (req.nxt < req.cur);
						mq_q    <= (req.nxt < req.cur) ? req.cur - req.nxt : req.nxt - req.cur;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= I_MUL;
					end
				end
				I_MUL: begin
					acc_q <= {acc_q[PROD_W-2:0], 1'b0}
						+ (mq_q[PULSE_W-1] ? PROD_W'(req.ph) : '0);
					mq_q  <= {mq_q[PULSE_W-2:0], 1'b0};
					if (cnt_q == CNT_W'(PULSE_W - 1)) begin
						cnt_q   <= '0;
						state_q <= I_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				I_DIV: begin
					acc_q <= {new_rem, acc_q[PULSE_W-2:0], ge};
					if (cnt_q == CNT_W'(PULSE_W - 1)) begin
						cnt_q   <= '0;
						state_q <= I_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				I_FIN: begin
					// a falling ramp rounds down, so a non-zero remainder takes one more
					pulse_q <= neg_q ? cur_q - quo - PULSE_W'(rem_nz) : cur_q + quo;
					state_q <= I_IDLE;
				end
				default: state_q <= I_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.pulse = pulse_q;

endmodule

>>> rtl/keyframe_servo_interpolator.sv
// Top level of the keyframe servo interpolator: control, tables and stream ports.
//
//  channel | direction | handshake            | content
//  --------+-----------+----------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready  | one request: keyframe load, channel load, tick
//  m_      | out       | m_tvalid / m_tready  | one pulse per active actuator, tlast on last
//  cfg_    | in        | cfg_wen only         | register write, no wait, no read-back
//
// In a running tick each driven actuator reads two keyframes from the single read port,
// the serial unit multiplies, divides and finishes, and the pulse is emitted; a final
// state then advances the phase and the step. After reset the keyframe store is swept
// to the rest pulse, one entry a cycle, 2**(clog2(ACTUATORS)+clog2(STEPS)) entries
// (128 at default size); s_tready stays low.
// A stalled m_ side holds the unit in its emit state; requests wait until the tick ends.
module keyframe_servo_interpolator import kfi_pkg::*; #(
	parameter int ACTUATORS = ACTUATORS_DEF,
	parameter int STEPS     = STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// actuator_index[2:0], step_index[6:3], angle[14:7], channel[18:15], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [USER_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// actuator_out[2:0], channel_out[6:3], pulse[18:7], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_wen,
	input  logic [1:0]            cfg_index,
	input  logic [TICK_W-1:0]     cfg_data
);

	localparam int AW     = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
	localparam int SW     = $clog2(STEPS);
	localparam int ADDR_W = AW + SW;
	localparam int NMAX   = (ACTUATORS < MAX_OUT) ? ACTUATORS : MAX_OUT;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_CUR,
		S_RD_NXT,
		S_START,
		S_CALC,
		S_EMIT,
		S_ADV
	} state_t;

	// configuration registers
	logic [4:0]        step_count_q;
	logic [3:0]        actuator_count_q;
	logic [TICK_W-1:0] step_ticks_q;
	logic              run_q;

	// pattern position and per-tick working registers
	state_t             state_q;
	logic [SW-1:0]      step_q;
	logic [TICK_W-1:0]  phase_q;
	logic [AW-1:0]      act_q;
	logic [SW-1:0]      cs_q;
	logic [SW-1:0]      nx_q;
	logic [TICK_W-1:0]  ph_q;
	logic [TICK_W-1:0]  tk_q;
	logic [3:0]         n_q;
	logic [PULSE_W-1:0] cur_q;

	// output register
	logic               m_tvalid_q;
	logic [2:0]         act_out_q;
	logic [3:0]         chan_out_q;
	logic [11:0]        pulse_out_q;
	logic               last_q;

	logic [3:0] chan_q [ACTUATORS];

	// request fields
	op_t        in_op;
	logic [2:0] in_act;
	logic [3:0] in_stp;
	logic [7:0] in_angle;
	logic [3:0] in_chan;
	logic       s_accept;

	assign in_op    = op_t'(s_tuser);
	assign in_act   = s_tdata[2:0];
	assign in_stp   = s_tdata[6:3];
	assign in_angle = s_tdata[14:7];
	assign in_chan  = s_tdata[18:15];

	// keyframe store and serial unit
	logic               clearing;
	logic               kf_we;
	logic [ADDR_W-1:0]  kf_waddr;
	logic [ADDR_W-1:0]  kf_raddr;
	logic [PULSE_W-1:0] kf_rdata;
	interp_req_t        ireq;
	interp_rsp_t        irsp;

	assign s_tready = (state_q == S_IDLE) && !clearing;
	assign s_accept = s_tvalid && s_tready;

	// drop loads aimed outside the tables
	assign kf_we    = s_accept && (in_op == OP_KEYFRAME)
		&& (32'(in_act) < ACTUATORS) && (32'(in_stp) < STEPS);
	assign kf_waddr = {AW'(in_act), SW'(in_stp)};
	assign kf_raddr = {act_q, (state_q == S_RD_NXT) ? nx_q : cs_q};

	kfi_kf_mem #(
		.ACTUATORS(ACTUATORS),
		.STEPS    (STEPS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (kf_we),
		.wr_addr (kf_waddr),
		.wr_data (angle_to_pulse(in_angle)),
		.rd_addr (kf_raddr),
		.rd_data (kf_rdata),
		.clearing(clearing)
	);

	assign ireq.start = (state_q == S_START);
	assign ireq.cur   = cur_q;
	assign ireq.nxt   = kf_rdata;
	assign ireq.ph    = ph_q;
	assign ireq.ticks = tk_q;

	kfi_interp u_interp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ireq),
		.rsp   (irsp)
	);

	// effective settings for the tick being accepted
	logic [4:0]        sc;
	logic [4:0]        steps_eff;
	logic [SW-1:0]     cs;
	logic [SW-1:0]     nx;
	logic [TICK_W-1:0] tk;
	logic [TICK_W-1:0] ph;
	logic [3:0]        n;
	logic              emit_last;
	logic              out_free;

	always_comb begin
		sc        = (step_count_q == 5'd0) ? 5'd1 : step_count_q;
		steps_eff = (32'(sc) > STEPS) ? 5'(STEPS) : sc;
		// a step left beyond a shortened pattern restarts at step zero
		cs        = (32'(step_q) >= 32'(steps_eff)) ? '0 : step_q;
		nx        = ((32'(cs) + 32'd1) >= 32'(steps_eff)) ? '0 : SW'(32'(cs) + 32'd1);
		tk        = (step_ticks_q == '0) ? 16'd1 : step_ticks_q;
		ph        = (phase_q >= tk) ? tk - 16'd1 : phase_q;
		n         = (32'(actuator_count_q) > NMAX) ? 4'(NMAX) : actuator_count_q;
	end

	assign emit_last = ((32'(act_q) + 32'd1) == 32'(n_q));
	assign out_free  = !m_tvalid_q || m_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q     <= STEP_COUNT_RST;
			actuator_count_q <= '0;
			step_ticks_q     <= STEP_TICKS_RST;
			run_q            <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_STEP_COUNT:     step_count_q     <= cfg_data[4:0];
				REG_ACTUATOR_COUNT: actuator_count_q <= cfg_data[3:0];
				REG_STEP_TICKS:     step_ticks_q     <= cfg_data;
				REG_RUN:            run_q            <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// channel table: small, read at the working actuator only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTUATORS; i++) begin
				chan_q[i] <= '0;
			end
		end else if (s_accept && (in_op == OP_CHANNEL) && (32'(in_act) < ACTUATORS)) begin
			chan_q[AW'(in_act)] <= in_chan;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			phase_q     <= '0;
			act_q       <= '0;
			cs_q        <= '0;
			nx_q        <= '0;
			ph_q        <= '0;
			tk_q        <= 16'd1;
			n_q         <= '0;
			cur_q       <= '0;
			m_tvalid_q  <= 1'b0;
			act_out_q   <= '0;
			chan_out_q  <= '0;
			pulse_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			// the emit state reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept && (in_op == OP_TICK)) begin
						if (!run_q) begin
							// stopped: rewind and give nothing
							step_q  <= '0;
							phase_q <= '0;
						end else begin
							cs_q    <= cs;
							nx_q    <= nx;
							ph_q    <= ph;
							tk_q    <= tk;
							n_q     <= n;
							act_q   <= '0;
							state_q <= (n == 4'd0) ? S_ADV : S_RD_CUR;
						end
					end
				end
				S_RD_CUR: state_q <= S_RD_NXT;
				S_RD_NXT: begin
					// read data now holds the current keyframe
					cur_q   <= kf_rdata;
					state_q <= S_START;
				end
				S_START: state_q <= S_CALC;
				S_CALC: begin
					if (irsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						act_out_q   <= 3'(act_q);
						chan_out_q  <= chan_q[act_q];
						pulse_out_q <= 12'(irsp.pulse);
						last_q      <= emit_last;
						if (emit_last) begin
							state_q <= S_ADV;
						end else begin
							act_q   <= act_q + 1'b1;
							state_q <= S_RD_CUR;
						end
					end
				end
				S_ADV: begin
					// advance the phase; at the end of a segment move to the next step
					if (ph_q == tk_q - 16'd1) begin
						phase_q <= '0;
						step_q  <= nx_q;
					end else begin
						phase_q <= ph_q + 16'd1;
						step_q  <= cs_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, pulse_out_q, chan_out_q, act_out_q};
	assign m_tlast  = last_q;

endmodule

>>> rtl/kfi_checker.sv
// Port-level checks of the keyframe servo interpolator, bound to the top level.
`include "assert_macros.svh"

module kfi_checker import kfi_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [USER_W-1:0]     s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// a stalled result holds its value
	`KFI_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// every pulse lies between the rest and full-travel counts
	`KFI_ASSERT_IMP(a_pulse_range, clk, arst_n, m_tvalid, (m_tdata[18:7] >= 12'(PULSE_MIN)) && (m_tdata[18:7] <= 12'(PULSE_MAX)))

	// a load or an unknown request never produces a result
	`KFI_ASSERT_NXT(a_load_quiet, clk, arst_n, s_tvalid && s_tready && (s_tuser != OP_TICK) && !m_tvalid, !m_tvalid)

	// no new request is taken while a tick still has results to give
	`KFI_ASSERT_NXT(a_tick_busy, clk, arst_n, m_tvalid && m_tready && !m_tlast, !s_tready)

endmodule

bind keyframe_servo_interpolator kfi_checker u_kfi_checker (.*);
